>>> design/bbs_pkg.sv
// Package for the bitmap boundary segment block.
// Holds field widths, register map codes, reset values and size defaults.
// Used by the segment channel interface, the top level and the testbench.
package bbs_pkg;

	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MAX_WIDTH_DEF  = 4096;

	localparam int CW = 13;
	localparam int RW = 11;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CW-1:0] WIDTH_RST  = CW'(4096);
	localparam logic [RW-1:0] HEIGHT_RST = RW'(1024);

	localparam int SEG_ABOVE  = 0;
	localparam int SEG_LEFT   = 1;
	localparam int SEG_TOP    = 2;
	localparam int SEG_BOTTOM = 3;
	localparam int SEG_LBORD  = 4;
	localparam int SEG_RBORD  = 5;
	localparam int NSEG       = 6;

endpackage

>>> design/bbs_pixel_if.sv
// Input channel of the boundary segment block: one bilevel pixel per item.
// Depends on nothing else.
interface bbs_pixel_if;
	logic valid;
	logic ready;
	logic pixel_white;

	modport source (output valid, output pixel_white, input ready);
	modport sink (input valid, input pixel_white, output ready);
endinterface

>>> design/bbs_seg_if.sv
// Output channel of the boundary segment block: one directed segment per item.
// Depends on bbs_pkg for the coordinate widths.
interface bbs_seg_if import bbs_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [CW-1:0] start_x;
	logic [RW-1:0] start_y;
	logic [CW-1:0] end_x;
	logic [RW-1:0] end_y;
	logic          last_of_run;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, output last_of_run, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, input last_of_run, output ready);
endinterface

>>> design/bitmap_boundary_segments_top.sv
// Top level of the bitmap boundary segment block.
// Depends on bbs_pkg, bbs_pixel_if and bbs_seg_if.
//
// Pixels arrive column by column, top to bottom, and each one yields up to four
// directed crack-edge segments with the black pixel on the right, in this order:
// the edge to the pixel above, the edge to the left pixel, then the top, bottom,
// left and right border edges. A pixel is taken into stage 1 together with its
// left neighbor from a read-first column store, and a segment sequencer then
// sends one segment per cycle through an output register while seg.ready does
// not stall it. The next pixel waits in stage 1 until the last segment of the
// pixel before is sent; interior pixels yield at most two segments. The column
// store needs no clearing after reset.
module bitmap_boundary_segments_top
	import bbs_pkg::*;
#(
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	bbs_pixel_if.sink         pix,
	bbs_seg_if.source         seg
);

	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XCW = $clog2(MAX_WIDTH + 1);
	localparam int YCW = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0] width_q;
	logic [RW-1:0] height_q;
	logic [XCW-1:0] w_eff;
	logic [YCW-1:0] h_eff;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          above_q;
	logic          last_row;
	logic          last_col;
	logic          accept;

	logic          col_mem [MAX_HEIGHT];
	logic          rd_q;

	logic          valid_s1;
	logic          white_s1;
	logic          above_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic          last_row_s1;
	logic          last_col_s1;
	logic          s1_adv;
	logic [NSEG-1:0] mask_s1;

	logic [NSEG-1:0] mask_s2;
	logic          above_black_s2;
	logic          left_black_s2;
	logic [CW-1:0] x_s2;
	logic [CW-1:0] xp_s2;
	logic [RW-1:0] y_s2;
	logic [RW-1:0] yp_s2;

	logic [NSEG-1:0] pick;
	logic [NSEG-1:0] rest;
	logic          out_free;
	logic          emit;
	logic          s2_free;
	logic [CW-1:0] nsx;
	logic [RW-1:0] nsy;
	logic [CW-1:0] nex;
	logic [RW-1:0] ney;

	logic          out_valid_q;
	logic [CW-1:0] sx_q;
	logic [RW-1:0] sy_q;
	logic [CW-1:0] ex_q;
	logic [RW-1:0] ey_q;
	logic          last_q;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[CW-1:0];
				REG_HEIGHT: height_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) w_eff = XCW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = XCW'(MAX_WIDTH);
		else w_eff = XCW'(width_q);
		if (height_q == '0) h_eff = YCW'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = YCW'(MAX_HEIGHT);
		else h_eff = YCW'(height_q);
	end

	// Scan position and pixel above.
	assign s1_adv   = valid_s1 && s2_free;
	assign pix.ready = !valid_s1 || s1_adv;
	assign accept   = pix.valid && pix.ready;
	assign last_row = (YCW'(row_q) + YCW'(1)) >= h_eff;
	assign last_col = (XCW'(col_q) + XCW'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			above_q <= 1'b0;
		end else if (accept) begin
			above_q <= pix.pixel_white;
			if (last_row) begin
				row_q <= '0;
				col_q <= last_col ? '0 : XW'(XCW'(col_q) + XCW'(1));
			end else begin
				row_q <= YW'(YCW'(row_q) + YCW'(1));
			end
		end
	end

	// Column store: read-first, so the old entry comes out as the new one goes in.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q           <= col_mem[row_q];
			col_mem[row_q] <= pix.pixel_white;
		end
	end

	// Stage 1: pixel with its neighbors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			white_s1    <= pix.pixel_white;
			above_s1    <= above_q;
			x_s1        <= col_q;
			y_s1        <= row_q;
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
		end
	end

	always_comb begin
		mask_s1             = '0;
		mask_s1[SEG_ABOVE]  = (y_s1 != '0) && (above_s1 != white_s1);
		mask_s1[SEG_LEFT]   = (x_s1 != '0) && (rd_q != white_s1);
		mask_s1[SEG_TOP]    = !white_s1 && (y_s1 == '0);
		mask_s1[SEG_BOTTOM] = !white_s1 && last_row_s1;
		mask_s1[SEG_LBORD]  = !white_s1 && (x_s1 == '0);
		mask_s1[SEG_RBORD]  = !white_s1 && last_col_s1;
	end

	// Stage 2: segment sequencer, lowest pending segment first.
	assign pick     = mask_s2 & (~mask_s2 + NSEG'(1));
	assign rest     = mask_s2 & ~pick;
	assign out_free = !out_valid_q || seg.ready;
	assign emit     = (mask_s2 != '0) && out_free;
	assign s2_free  = (mask_s2 == '0) || (emit && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv) begin
			mask_s2 <= mask_s1;
		end else if (emit) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			above_black_s2 <= !above_s1;
			left_black_s2  <= !rd_q;
			x_s2           <= CW'(x_s1);
			xp_s2          <= CW'(XCW'(x_s1) + XCW'(1));
			y_s2           <= RW'(y_s1);
			yp_s2          <= RW'(YCW'(y_s1) + YCW'(1));
		end
	end

	always_comb begin
		nsx = xp_s2;
		nsy = y_s2;
		nex = xp_s2;
		ney = yp_s2;
		if (pick[SEG_ABOVE]) begin
			nsx = above_black_s2 ? xp_s2 : x_s2;
			nsy = y_s2;
			nex = above_black_s2 ? x_s2 : xp_s2;
			ney = y_s2;
		end else if (pick[SEG_LEFT]) begin
			nsx = x_s2;
			nsy = left_black_s2 ? y_s2 : yp_s2;
			nex = x_s2;
			ney = left_black_s2 ? yp_s2 : y_s2;
		end else if (pick[SEG_TOP]) begin
			nsx = x_s2;
			nsy = '0;
			nex = xp_s2;
			ney = '0;
		end else if (pick[SEG_BOTTOM]) begin
			nsx = xp_s2;
			nsy = yp_s2;
			nex = x_s2;
			ney = yp_s2;
		end else if (pick[SEG_LBORD]) begin
			nsx = '0;
			nsy = yp_s2;
			nex = '0;
			ney = y_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sx_q   <= nsx;
			sy_q   <= nsy;
			ex_q   <= nex;
			ey_q   <= ney;
			last_q <= (rest == '0);
		end
	end

	assign seg.valid       = out_valid_q;
	assign seg.start_x     = sx_q;
	assign seg.start_y     = sy_q;
	assign seg.end_x       = ex_q;
	assign seg.end_y       = ey_q;
	assign seg.last_of_run = last_q;

	// A segment that is not the last of its pixel leaves the rest pending.
	a_run_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> mask_s2 != '0)
		else $error("segment run ended without its last mark");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < MAX_HEIGHT && 32'(col_q) < MAX_WIDTH)
		else $error("scan position outside the bitmap bounds");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted segment not presented");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_s2 != '0) && !out_free |=> mask_s2 == $past(mask_s2))
		else $error("pending segments changed while output stalled");

endmodule

>>> tb/sv/bitmap_boundary_segments_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the bitmap boundary segment block: streams bilevel pixels,
// predicts the directed crack-edge segments and checks every one of them.
// Depends on bbs_pkg, bbs_pixel_if, bbs_seg_if and bitmap_boundary_segments_top.
module bitmap_boundary_segments_top_tb
	import bbs_pkg::*;
();

	localparam int DRAIN_CYCLES = 12;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [CW-1:0] start_x;
		logic [RW-1:0] start_y;
		logic [CW-1:0] end_x;
		logic [RW-1:0] end_y;
		logic          last_of_run;
	} segment_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	bbs_pixel_if pixel_bus();
	bbs_seg_if segment_bus();

	bitmap_boundary_segments_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pixel_bus.sink),
		.seg     (segment_bus.source)
	);

	// Shadow of the block's registers and scan state.
	logic [CW-1:0] width_reg;
	logic [RW-1:0] height_reg;
	bit left_column [MAX_HEIGHT_DEF];
	bit pixel_above_white;
	int unsigned col_at;
	int unsigned row_at;

	bit pixel_backlog[$];
	segment_t pending_segments[$];
	segment_t seg_want;
	int unsigned pixels_pushed;
	int unsigned pixels_accepted;
	int unsigned segments_checked;
	int unsigned mismatches;
	int unsigned holdoffs_requested;
	int unsigned holdoffs_served;
	int burst_left;
	int gap_left;
	int holdoff_left;
	int unsigned rx_clock;
	rx_pattern_t rx_pattern;
	int unsigned quiet_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic segment_t make_seg(int unsigned sx, int unsigned sy, int unsigned ex,
		int unsigned ey);
		segment_t s;
		s.start_x = CW'(sx);
		s.start_y = RW'(sy);
		s.end_x = CW'(ex);
		s.end_y = RW'(ey);
		s.last_of_run = 1'b0;
		return s;
	endfunction

	function automatic void trace_pixel(logic white);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		bit final_row;
		bit final_col;
		segment_t run[$];
		w = eff_dim(width_reg, MAX_WIDTH_DEF);
		h = eff_dim(height_reg, MAX_HEIGHT_DEF);
		x = col_at;
		y = row_at;
		final_row = (y + 1 >= h);
		final_col = (x + 1 >= w);
		if (y > 0 && pixel_above_white != white)
			run = {run, (pixel_above_white ? make_seg(x, y, x + 1, y)
				: make_seg(x + 1, y, x, y))};
		if (x > 0 && left_column[y] != white)
			run = {run, (left_column[y] ? make_seg(x, y + 1, x, y)
				: make_seg(x, y, x, y + 1))};
		if (!white) begin
			if (y == 0) run = {run, make_seg(x, 0, x + 1, 0)};
			if (final_row) run = {run, make_seg(x + 1, y + 1, x, y + 1)};
			if (x == 0) run = {run, make_seg(0, y + 1, 0, y)};
			if (final_col) run = {run, make_seg(x + 1, y, x + 1, y + 1)};
		end
		if (run.size() != 0) run[run.size() - 1].last_of_run = 1'b1;
		pending_segments = {pending_segments, run};
		left_column[y] = white;
		pixel_above_white = white;
		if (final_row) begin
			row_at = 0;
			col_at = final_col ? 0 : x + 1;
		end else begin
			row_at = y + 1;
		end
	endfunction

	task automatic report_fault(string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(string name, logic [CW-1:0] got, logic [CW-1:0] want);
		if (got !== want)
			report_fault($sformatf("segment %0d field %s got %0d, expected %0d",
				segments_checked, name, got, want));
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		logic [APB_DW-1:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_WIDTH) width_reg = CW'(value);
		else height_reg = RW'(value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_WIDTH ? readback[CW-1:0] !== width_reg
			: readback[RW-1:0] !== height_reg)
			report_fault($sformatf("register %0d read back %0d", idx, readback));
	endtask

	task automatic offer_pixel(bit white);
		pixel_backlog = {pixel_backlog, white};
		pixels_pushed++;
	endtask

	task automatic offer_run(logic [7:0] shades, int n);
		for (int i = 0; i < n; i++) offer_pixel(shades[i]);
	endtask

	task automatic settle();
		while (pixels_accepted != pixels_pushed || pending_segments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.valid <= 1'b0;
			pixel_bus.pixel_white <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (pixel_bus.valid && pixel_bus.ready) begin
				trace_pixel(pixel_bus.pixel_white);
				pixels_accepted++;
			end
			if (!pixel_bus.valid || pixel_bus.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					pixel_bus.valid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					pixel_bus.valid <= 1'b1;
					pixel_bus.pixel_white <= pixel_backlog.pop_front();
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					pixel_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_bus.ready <= 1'b0;
			rx_clock <= 0;
			rx_pattern <= RX_OPEN;
			holdoff_left <= 0;
		end else begin
			if (segment_bus.valid && segment_bus.ready) begin
				if (pending_segments.size() == 0) begin
					report_fault($sformatf("unexpected segment (%0d,%0d)->(%0d,%0d)",
						segment_bus.start_x, segment_bus.start_y,
						segment_bus.end_x, segment_bus.end_y));
				end else begin
					seg_want = pending_segments.pop_front();
					check_field("start_x", segment_bus.start_x, seg_want.start_x);
					check_field("start_y", CW'(segment_bus.start_y), CW'(seg_want.start_y));
					check_field("end_x", segment_bus.end_x, seg_want.end_x);
					check_field("end_y", CW'(segment_bus.end_y), CW'(seg_want.end_y));
					check_field("last_of_run", CW'(segment_bus.last_of_run),
						CW'(seg_want.last_of_run));
					segments_checked++;
				end
			end
			rx_clock <= rx_clock + 1;
			if (rx_clock[5:0] == 0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
			if (holdoff_left != 0) begin
				holdoff_left <= holdoff_left - 1;
				segment_bus.ready <= 1'b0;
			end else if (holdoffs_served != holdoffs_requested) begin
				holdoffs_served <= holdoffs_served + 1;
				holdoff_left <= HOLDOFF_CYCLES;
				segment_bus.ready <= 1'b0;
			end else begin
				case (rx_pattern)
				RX_OPEN: segment_bus.ready <= 1'b1;
				RX_COIN: segment_bus.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: segment_bus.ready <= (rx_clock[1:0] == 0);
				default: segment_bus.ready <= (rx_clock % 5 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_bus.valid && pixel_bus.ready) || (segment_bus.valid && segment_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned random_pixels;
		int unsigned phase;
		int unsigned count;
		int unsigned style;
		int unsigned h_now;
		int unsigned w_new;
		int unsigned h_new;
		bit shade;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_bus.valid = 1'b0;
		pixel_bus.pixel_white = 1'b0;
		segment_bus.ready = 1'b0;
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		pixel_above_white = 1'b0;
		col_at = 0;
		row_at = 0;
		pixels_pushed = 0;
		pixels_accepted = 0;
		segments_checked = 0;
		mismatches = 0;
		holdoffs_requested = 0;
		holdoffs_served = 0;
		quiet_cycles = 0;
		foreach (left_column[i]) left_column[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes, then a height cut short in the middle of the first column.
		offer_run(8'b0010, 4);
		settle();
		write_reg(REG_HEIGHT, 3);
		offer_run(8'b1010, 4);
		settle();
		// A narrower width ends the frame at the current column.
		write_reg(REG_WIDTH, 2);
		offer_run(8'b000, 3);
		settle();
		// Zero sizes act as one: every pixel is a frame of its own.
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 0);
		offer_run(8'b010, 3);
		settle();
		// Oversized registers act as the largest sizes.
		write_reg(REG_WIDTH, 8191);
		write_reg(REG_HEIGHT, 2047);
		offer_run(8'b101, 3);
		settle();

		// The height only shrinks inside a frame, so no row of the column store
		// is read before it was written.
		phase = 0;
		random_pixels = 0;
		while (random_pixels < 350) begin
			phase++;
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
				0: w_new = 0;
				1: w_new = $urandom_range(MAX_WIDTH_DEF, 8191);
				default: w_new = $urandom_range(1, 8);
				endcase
				write_reg(REG_WIDTH, w_new);
			end
			if ($urandom_range(0, 2) != 0) begin
				h_now = eff_dim(height_reg, MAX_HEIGHT_DEF);
				if (col_at == 0 && row_at == 0) begin
					case ($urandom_range(0, 9))
					0: h_new = 0;
					1: h_new = $urandom_range(MAX_HEIGHT_DEF, 2047);
					default: h_new = $urandom_range(1, 9);
					endcase
				end else begin
					h_new = $urandom_range(0, h_now < 9 ? h_now : 9);
				end
				write_reg(REG_HEIGHT, h_new);
			end
			count = $urandom_range(4, 40);
			if (phase == 4) begin
				holdoffs_requested++;
				count = 80;
			end
			style = $urandom_range(0, 2);
			shade = 1'($urandom_range(0, 1));
			repeat (count) begin
				case (style)
				0: shade = 1'($urandom_range(0, 1));
				1: if ($urandom_range(0, 4) == 0) shade = !shade;
				default: shade = ($urandom_range(0, 7) == 0);
				endcase
				offer_pixel(shade);
			end
			random_pixels += count;
			settle();
		end

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> bitmap_boundary_segments_top.f
design/bbs_pkg.sv
design/bbs_pixel_if.sv
design/bbs_seg_if.sv
design/bitmap_boundary_segments_top.sv
tb/sv/bitmap_boundary_segments_top_tb.sv
